@@ sv/clt_pkg.sv @@
// clt_pkg: phase, role and error codes, character constants and the result word type
// shared by the config line tokenizer modules; no dependencies

package clt_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChEquals = 8'h3d;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChEnd = 8'h00;

  typedef enum logic [6:0] {
    PH_LINE    = 7'b0000001,
    PH_COMMENT = 7'b0000010,
    PH_NAME    = 7'b0000100,
    PH_AFTNAME = 7'b0001000,
    PH_AFTEQ   = 7'b0010000,
    PH_VALUE   = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_SKIP  = 2'd0,
    ROLE_NAME  = 2'd1,
    ROLE_VALUE = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_END_NAME = 2'd1,
    ERR_NO_EQ    = 2'd2,
    ERR_END_EQ   = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] out_byte;
    role_e      role;
    logic       record_done;
    logic       text_end;
    err_e       error_code;
  } res_t;

endpackage

@@ sv/clt_phase.sv @@
// clt_phase: parse phase register and the per-byte decode into one result word
// depends on clt_pkg

module clt_phase import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       step_i,
  output res_t       res_o
);

  phase_e phase_q, phase_d;
  logic   is_end, is_blank, is_line_end, is_name_byte;
  role_e  role;
  logic   done;
  err_e   err;

  assign is_end = (byte_i == ChEnd);
  assign is_blank = (byte_i inside {[8'h01:ChSpace]});
  assign is_line_end = (byte_i == ChCr) || (byte_i == ChLf);
  assign is_name_byte = (byte_i >= ChUpperA) || (byte_i inside {[ChZero:ChNine]});

  always_comb begin
    phase_d = phase_q;
    role = ROLE_SKIP;
    done = 1'b0;
    err = ERR_NONE;
    case (phase_q)
      PH_LINE: begin
        if (is_end || is_blank) begin
          phase_d = PH_LINE;
        end else if (byte_i < ChUpperA) begin
          phase_d = PH_COMMENT;
        end else begin
          role = ROLE_NAME;
          phase_d = PH_NAME;
        end
      end
      PH_COMMENT: begin
        if (is_end || is_line_end) phase_d = PH_LINE;
      end
      PH_NAME: begin
        if (is_end) begin
          err = ERR_END_NAME;
          phase_d = PH_LINE;
        end else if (is_name_byte) begin
          role = ROLE_NAME;
        end else begin
          phase_d = PH_AFTNAME;
        end
      end
      PH_AFTNAME: begin
        if (is_blank) begin
          phase_d = PH_AFTNAME;
        end else if (byte_i == ChEquals) begin
          phase_d = PH_AFTEQ;
        end else begin
          err = ERR_NO_EQ;
          phase_d = is_end ? PH_LINE : PH_ERROR;
        end
      end
      PH_AFTEQ: begin
        if (is_end) begin
          err = ERR_END_EQ;
          phase_d = PH_LINE;
        end else if (!is_blank) begin
          role = ROLE_VALUE;
          phase_d = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (is_end || is_line_end) begin
          done = 1'b1;
          phase_d = PH_LINE;
        end else begin
          role = ROLE_VALUE;
        end
      end
      default: begin
        phase_d = is_end ? PH_LINE : PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    res_o.out_byte = byte_i;
    res_o.role = role;
    res_o.record_done = done;
    res_o.text_end = is_end;
    res_o.error_code = err;
  end

endmodule

@@ sv/clt_out_stage.sv @@
// clt_out_stage: result register with valid/stall handshake toward the sink
// depends on clt_pkg

module clt_out_stage import clt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_valid_i,
  input  res_t load_res_i,
  output logic ready_o,
  output logic valid_o,
  input  logic stall_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_valid_i) begin
      res_q <= load_res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o = res_q;

endmodule

@@ sv/config_line_tokenizer.sv @@
// config_line_tokenizer: top level, input register, phase decode and result register
// depends on clt_pkg, clt_phase and clt_out_stage

// Tags each byte of a "name = value" configuration text with its role, a
// record-complete flag, an end-of-text flag and an error code. One byte is
// taken per cycle and one result word leaves per cycle; a byte passes
// through the input register and then its result word is loaded into the
// result register. The rate is set by the parse phase register, which is
// updated once per byte as that byte's result is loaded. Stall on the output
// side holds the result register and then the input register.

module config_line_tokenizer import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] role_o,
  output logic       record_done_o,
  output logic       text_end_o,
  output logic [1:0] error_code_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_ready;
  logic       step;
  res_t       dec_res;
  res_t       out_res;

  assign step = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
    end
  end

  clt_phase u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .step_i (step),
    .res_o  (dec_res)
  );

  clt_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_res_i   (dec_res),
    .ready_o      (out_ready),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .res_o        (out_res)
  );

  assign out_byte_o = out_res.out_byte;
  assign role_o = out_res.role;
  assign record_done_o = out_res.record_done;
  assign text_end_o = out_res.text_end;
  assign error_code_o = out_res.error_code;

  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_done_o |-> error_code_o == ERR_NONE)
    else $error("record completed together with an error");

  a_end_err_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o == ERR_END_NAME || error_code_o == ERR_END_EQ)
      |-> text_end_o && out_byte_o == ChEnd)
    else $error("end-of-text error on a nonzero byte");

  a_name_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && role_o == ROLE_NAME
      |-> out_byte_o >= ChZero && out_byte_o != ChEquals && !text_end_o)
    else $error("name role on a byte that cannot be part of a name");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("input register lost a word while stalled");

endmodule
